### hdl/montgomery_product_unit_macros.svh
// ----------------------------------------------------------------------------
// Montgomery product unit assertion macros
// Assertion helpers used by the port-level checker of the Montgomery product unit.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_PRODUCT_UNIT_MACROS_SVH
`define MONTGOMERY_PRODUCT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mpu_pkg.sv
// ----------------------------------------------------------------------------
// Montgomery product unit package
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mpu_pkg;

  localparam int unsigned FIELD_W       = 64;
  localparam int unsigned RADIX_W       = 7;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned DEFAULT_WIDTH = 64;

  localparam logic [FIELD_W-1:0] MODULUS_RST     = 64'd3;
  localparam logic [RADIX_W-1:0] RADIX_BITS_RST  = 7'd2;
  localparam logic [FIELD_W-1:0] NEG_INVERSE_RST = 64'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_RADIX_BITS  = 2'd1,
    CFG_NEG_INVERSE = 2'd2
  } cfg_idx_e;

endpackage

### hdl/mpu_in_if.sv
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel that carries one operand pair per transaction.
// ----------------------------------------------------------------------------
interface mpu_in_if import mpu_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] a_operand;
  logic [FIELD_W-1:0] b_operand;

  modport source (output valid, output a_operand, output b_operand, input ready);
  modport sink   (input valid, input a_operand, input b_operand, output ready);

endinterface

### hdl/mpu_out_if.sv
// ----------------------------------------------------------------------------
// Product channel
// Valid/ready channel that carries one Montgomery product per transaction.
// ----------------------------------------------------------------------------
interface mpu_out_if import mpu_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);

endinterface

### hdl/mpu_mult.sv
// ----------------------------------------------------------------------------
// Pipelined multiplier
// Two-stage full-width multiplier: half-width partial products, then their sum.
// A side payload travels along with each transaction.
// ----------------------------------------------------------------------------
module mpu_mult import mpu_pkg::*; #(
  parameter int unsigned OpW   = DEFAULT_WIDTH,
  parameter int unsigned SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     x_i,
  input  logic [OpW-1:0]     y_i,
  input  logic [SideW-1:0]   side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2*OpW-1:0]   prod_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned LoW   = (OpW + 1) / 2;
  localparam int unsigned HiW   = OpW - LoW;
  localparam int unsigned ProdW = 2 * OpW;

  logic [2*LoW-1:0]   pp_ll_d, pp_ll_q;
  logic [OpW-1:0]     pp_lh_d, pp_lh_q;
  logic [OpW-1:0]     pp_hl_d, pp_hl_q;
  logic [2*HiW-1:0]   pp_hh_d, pp_hh_q;
  logic [SideW-1:0]   side_a_q, side_b_q;
  logic               valid_a_q, valid_b_q;
  logic               ready_a, ready_b;
  logic [ProdW-1:0]   prod_d, prod_q;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_comb begin
    pp_ll_d = x_i[LoW-1:0]   * y_i[LoW-1:0];
    pp_lh_d = x_i[LoW-1:0]   * y_i[OpW-1:LoW];
    pp_hl_d = x_i[OpW-1:LoW] * y_i[LoW-1:0];
    pp_hh_d = x_i[OpW-1:LoW] * y_i[OpW-1:LoW];
  end

  assign prod_d = ProdW'(pp_ll_q)
                + (ProdW'(pp_lh_q) << LoW)
                + (ProdW'(pp_hl_q) << LoW)
                + (ProdW'(pp_hh_q) << (2 * LoW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) valid_a_q <= in_valid_i;
      if (ready_b) valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      pp_ll_q  <= pp_ll_d;
      pp_lh_q  <= pp_lh_d;
      pp_hl_q  <= pp_hl_d;
      pp_hh_q  <= pp_hh_d;
      side_a_q <= side_i;
    end
    if (ready_b && valid_a_q) begin
      prod_q   <= prod_d;
      side_b_q <= side_a_q;
    end
  end

  assign out_valid_o = valid_b_q;
  assign prod_o      = prod_q;
  assign side_o      = side_b_q;

endmodule

### hdl/mpu_reduce.sv
// ----------------------------------------------------------------------------
// Montgomery reduction tail
// Adds T and m*N, shifts right by k and applies one conditional subtraction.
// ----------------------------------------------------------------------------
module mpu_reduce import mpu_pkg::*; #(
  parameter int unsigned OpW = DEFAULT_WIDTH,
  parameter int unsigned KW  = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2*OpW-1:0] t_i,
  input  logic [2*OpW-1:0] mn_i,
  input  logic [KW-1:0]    k_i,
  input  logic [OpW-1:0]   modulus_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OpW-1:0]   product_o
);

  localparam int unsigned SumW = 2 * OpW + 1;

  logic [SumW-1:0] sum_d, sum_q;
  logic [KW-1:0]   k_q;
  logic [SumW-1:0] quot_d, quot_q;
  logic [OpW-1:0]  res_d, res_q;
  logic            valid_s_q, valid_u_q, valid_o_q;
  logic            ready_s, ready_u, ready_o;

  assign ready_o    = !valid_o_q || out_ready_i;
  assign ready_u    = !valid_u_q || ready_o;
  assign ready_s    = !valid_s_q || ready_u;
  assign in_ready_o = ready_s;

  // The sum keeps its carry so the compare against N sees the full quotient.
  assign sum_d  = {1'b0, t_i} + {1'b0, mn_i};
  assign quot_d = sum_q >> k_q;

  always_comb begin
    if (quot_q >= SumW'(modulus_i)) begin
      res_d = quot_q[OpW-1:0] - modulus_i;
    end else begin
      res_d = quot_q[OpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s_q <= 1'b0;
      valid_u_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else begin
      if (ready_s) valid_s_q <= in_valid_i;
      if (ready_u) valid_u_q <= valid_s_q;
      if (ready_o) valid_o_q <= valid_u_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s && in_valid_i) begin
      sum_q <= sum_d;
      k_q   <= k_i;
    end
    if (ready_u && valid_s_q) quot_q <= quot_d;
    if (ready_o && valid_u_q) res_q  <= res_d;
  end

  assign out_valid_o = valid_o_q;
  assign product_o   = res_q;

endmodule

### hdl/montgomery_product_unit.sv
// ----------------------------------------------------------------------------
// Montgomery product unit
// Pipelined REDC: returns a*b*R^-1 with one conditional subtraction of N.
// ----------------------------------------------------------------------------
// The unit takes one operand pair per clock cycle unless the output stalls.
// Three two-stage multipliers (a*b, T*n' mod R, m*N) of four half-width
// partial products each come first; the add of T and m*N, the shift by k and
// the final compare-and-subtract are registered stages after them. Each stage
// holds its transaction while the next is full, so a stalled output backs
// the pipeline up one stage at a time and empty slots are filled. The user
// must write registers only while no transaction is in flight (not enforced).
module montgomery_product_unit import mpu_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpu_in_if.sink                in_i,
  mpu_out_if.source             out_o
);

  localparam int unsigned KW    = $clog2(WIDTH + 1);
  localparam int unsigned ProdW = 2 * WIDTH;

  logic [FIELD_W-1:0] modulus_q, neg_inverse_q;
  logic [RADIX_W-1:0] radix_bits_q;
  logic [KW-1:0]      k_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= MODULUS_RST;
      radix_bits_q  <= RADIX_BITS_RST;
      neg_inverse_q <= NEG_INVERSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS:     modulus_q     <= cfg_data_i[FIELD_W-1:0];
        CFG_RADIX_BITS:  radix_bits_q  <= cfg_data_i[RADIX_W-1:0];
        CFG_NEG_INVERSE: neg_inverse_q <= cfg_data_i[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // A radix wider than the datapath acts as the full width.
  always_comb begin
    if (radix_bits_q > RADIX_W'(WIDTH)) begin
      k_clamped = KW'(WIDTH);
    end else begin
      k_clamped = radix_bits_q[KW-1:0];
    end
  end

  // T = a * b
  logic             v1, r1;
  logic [ProdW-1:0] t1;
  logic [KW-1:0]    k1;

  mpu_mult #(.OpW(WIDTH), .SideW(KW)) u_mult_ab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .x_i        (in_i.a_operand[WIDTH-1:0]),
    .y_i        (in_i.b_operand[WIDTH-1:0]),
    .side_i     (k_clamped),
    .out_valid_o(v1),
    .out_ready_i(r1),
    .prod_o     (t1),
    .side_o     (k1)
  );

  // m = (T mod 2^W) * n', cut to k bits below
  logic                  v2, r2;
  logic [ProdW-1:0]      lo_prod;
  logic [KW+ProdW-1:0]   side2;
  logic [KW-1:0]         k2;
  logic [ProdW-1:0]      t2;
  logic [WIDTH:0]        kmask_full;
  logic [WIDTH-1:0]      m_val;

  mpu_mult #(.OpW(WIDTH), .SideW(KW + ProdW)) u_mult_m (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v1),
    .in_ready_o (r1),
    .x_i        (t1[WIDTH-1:0]),
    .y_i        (neg_inverse_q[WIDTH-1:0]),
    .side_i     ({k1, t1}),
    .out_valid_o(v2),
    .out_ready_i(r2),
    .prod_o     (lo_prod),
    .side_o     (side2)
  );

  assign k2         = side2[KW+ProdW-1:ProdW];
  assign t2         = side2[ProdW-1:0];
  assign kmask_full = ({{WIDTH{1'b0}}, 1'b1} << k2) - 1'b1;
  assign m_val      = lo_prod[WIDTH-1:0] & kmask_full[WIDTH-1:0];

  // m * N
  logic                v3, r3;
  logic [ProdW-1:0]    mn_prod;
  logic [KW+ProdW-1:0] side3;
  logic                res_valid;
  logic [WIDTH-1:0]    res;

  mpu_mult #(.OpW(WIDTH), .SideW(KW + ProdW)) u_mult_mn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v2),
    .in_ready_o (r2),
    .x_i        (m_val),
    .y_i        (modulus_q[WIDTH-1:0]),
    .side_i     ({k2, t2}),
    .out_valid_o(v3),
    .out_ready_i(r3),
    .prod_o     (mn_prod),
    .side_o     (side3)
  );

  mpu_reduce #(.OpW(WIDTH), .KW(KW)) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v3),
    .in_ready_o (r3),
    .t_i        (side3[ProdW-1:0]),
    .mn_i       (mn_prod),
    .k_i        (side3[KW+ProdW-1:ProdW]),
    .modulus_i  (modulus_q[WIDTH-1:0]),
    .out_valid_o(res_valid),
    .out_ready_i(out_o.ready),
    .product_o  (res)
  );

  assign out_o.valid   = res_valid;
  assign out_o.product = FIELD_W'(res);

endmodule

### hdl/mpu_checker.sv
// ----------------------------------------------------------------------------
// Montgomery product unit checker
// Port-level properties of the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "montgomery_product_unit_macros.svh"

module mpu_checker import mpu_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] out_product_i
);

  // A stalled result must stay offered and unchanged.
  `MPU_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `MPU_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_product_i), "result changed while stalled")

  // With the output stage free to move, every stage can take a transaction.
  `MPU_ASSERT_NOW(a_in_ready_free, clk_i, rst_ni, !out_valid_i || out_ready_i, in_ready_i, "input stalled with a free pipeline")

  // Bits above the datapath width read as zero.
  `MPU_ASSERT_NOW(a_upper_zero, clk_i, rst_ni, out_valid_i, (out_product_i >> WIDTH) == FIELD_W'(0), "product has bits above the width")

endmodule

bind montgomery_product_unit mpu_checker #(.WIDTH(WIDTH)) u_mpu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_product_i(out_o.product)
);

### tb/sv/mpu_product_checker.sv
// ----------------------------------------------------------------------------
// Montgomery product checker
// Watches the operand, product and configuration ports of the Montgomery
// product unit. It predicts the REDC product of every accepted operand pair
// and compares each accepted product with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mpu_product_checker import mpu_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpu_in_if                     in_mon,
  mpu_out_if                    out_mon,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] product;
  } product_expect_t;

  product_expect_t    expected_q[$];
  logic [FIELD_W-1:0] modulus_q  = MODULUS_RST;
  logic [RADIX_W-1:0] radix_q    = RADIX_BITS_RST;
  logic [FIELD_W-1:0] neg_inv_q  = NEG_INVERSE_RST;
  int unsigned        mismatches = 0;
  int unsigned        pending    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  // u = (a*b + m*N) >> k with m = (a*b * n') mod 2^k, then at most one
  // subtraction of N. The sum keeps its carry, and u is compared with N at
  // full precision before it is cut to the datapath width.
  function automatic logic [FIELD_W-1:0] montgomery_redc(
    input logic [FIELD_W-1:0] a,
    input logic [FIELD_W-1:0] b,
    input logic [FIELD_W-1:0] modulus,
    input logic [RADIX_W-1:0] radix,
    input logic [FIELD_W-1:0] neg_inv
  );
    logic [FIELD_W-1:0]   wmask;
    logic [FIELD_W-1:0]   kmask;
    logic [FIELD_W-1:0]   am;
    logic [FIELD_W-1:0]   bm;
    logic [FIELD_W-1:0]   nm;
    logic [FIELD_W-1:0]   im;
    logic [FIELD_W-1:0]   m;
    logic [2*FIELD_W-1:0] t;
    logic [2*FIELD_W-1:0] mn;
    logic [2*FIELD_W:0]   u;
    int unsigned          k;
    wmask = {FIELD_W{1'b1}} >> (FIELD_W - WIDTH);
    am    = a & wmask;
    bm    = b & wmask;
    nm    = modulus & wmask;
    im    = neg_inv & wmask;
    k     = radix;
    if (k > WIDTH) k = WIDTH;
    kmask = (k == 0) ? '0 : ({FIELD_W{1'b1}} >> (FIELD_W - k));
    t     = (2*FIELD_W)'(am) * (2*FIELD_W)'(bm);
    m     = t[FIELD_W-1:0] * im;
    m     = m & kmask;
    mn    = (2*FIELD_W)'(m) * (2*FIELD_W)'(nm);
    u     = ((2*FIELD_W+1)'(t) + (2*FIELD_W+1)'(mn)) >> k;
    if (u >= (2*FIELD_W+1)'(nm)) u = u - (2*FIELD_W+1)'(nm);
    return u[FIELD_W-1:0] & wmask;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    product_expect_t entry;
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      radix_q   <= RADIX_BITS_RST;
      neg_inv_q <= NEG_INVERSE_RST;
      expected_q.delete();
      pending   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODULUS:     modulus_q <= cfg_data_i[FIELD_W-1:0];
          CFG_RADIX_BITS:  radix_q   <= cfg_data_i[RADIX_W-1:0];
          CFG_NEG_INVERSE: neg_inv_q <= cfg_data_i[FIELD_W-1:0];
          default: ;
        endcase
      end
      // Retire before predicting: a product never belongs to the pair
      // accepted in the same cycle.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected product %h with nothing outstanding",
                     $realtime, out_mon.product);
          mismatches++;
        end else begin
          entry = expected_q.pop_front();
          if (out_mon.product !== entry.product) begin
            if (mismatches < 10)
              $display("[%0t] product mismatch: a=%h b=%h expected %h got %h",
                       $realtime, entry.a, entry.b, entry.product, out_mon.product);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        entry.a       = in_mon.a_operand;
        entry.b       = in_mon.b_operand;
        entry.product = montgomery_redc(in_mon.a_operand, in_mon.b_operand,
                                        modulus_q, radix_q, neg_inv_q);
        expected_q.push_back(entry);
      end
      pending <= expected_q.size();
    end
  end

endmodule

### tb/sv/montgomery_product_unit_tb.sv
// ----------------------------------------------------------------------------
// Montgomery product unit testbench
// Drives operand pairs in bursts through a series of modulus and radix
// settings, including degenerate ones, while the product side stalls on its
// own pattern. A checker beside the unit predicts and compares every product.
// ----------------------------------------------------------------------------
module montgomery_product_unit_tb import mpu_pkg::*; ;

  localparam int unsigned        HOLD_CYCLES  = 80;
  localparam int unsigned        DRAIN_CYCLES = 20;
  localparam int unsigned        RUN_LIMIT    = 3_000_000;
  localparam logic [FIELD_W-1:0] ALL_ONES     = '1;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           hold_requests = 0;
  int unsigned           holds_served  = 0;
  int unsigned           mismatch_count;
  int unsigned           products_pending;

  mpu_in_if  in_ch ();
  mpu_out_if out_ch ();

  montgomery_product_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  mpu_product_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (products_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [FIELD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly reduced operands, with some edge values and some unreduced ones.
  function automatic logic [FIELD_W-1:0] random_operand(input logic [FIELD_W-1:0] n);
    logic [FIELD_W-1:0] w;
    w = random_word();
    case ($urandom_range(0, 9))
      7: begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 1;
          2:       w = n - 1;
          default: w = ALL_ONES;
        endcase
      end
      8, 9: ;
      default: begin
        if (n != 0) w = w % n;
      end
    endcase
    return w;
  endfunction

  // -N^-1 mod 2^k by Newton iteration; each step doubles the correct bits.
  function automatic logic [FIELD_W-1:0] neg_inverse_of(input logic [FIELD_W-1:0] n,
                                                         input int unsigned k);
    logic [FIELD_W-1:0] x;
    if (k == 0) return '0;
    x = n;
    repeat (6) x = x * (FIELD_W'(2) - n * x);
    x = -x;
    return x & ({FIELD_W{1'b1}} >> (FIELD_W - k));
  endfunction

  task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    logic taken;
    in_ch.valid     <= 1'b1;
    in_ch.a_operand <= a;
    in_ch.b_operand <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_ch.valid     <= 1'b0;
    in_ch.a_operand <= random_word();
    in_ch.b_operand <= random_word();
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_random_pairs(input int unsigned count, input logic [FIELD_W-1:0] n,
                                   input int unsigned max_burst);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, max_burst);
      while (burst != 0 && sent < count) begin
        send_pair(random_operand(n), random_operand(n));
        sent++;
        burst--;
      end
      pause_sender($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3));
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (products_pending != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] n, input logic [CFG_DATA_W-1:0] radix_word,
                            input logic [FIELD_W-1:0] neg_inv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MODULUS;
    cfg_data_i <= n;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RADIX_BITS;
    cfg_data_i <= radix_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NEG_INVERSE;
    cfg_data_i <= neg_inv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // The product side stalls on a pattern that steps through four modes in turn, and
  // holds off for a long stretch whenever the stimulus asks for it.
  initial begin : product_sink
    int unsigned hold_left;
    int unsigned tick;
    hold_left    = 0;
    tick         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case ((tick / 256) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 99) < 60);
          2:       out_ch.ready <= ((tick % 7) > 2);
          default: out_ch.ready <= ($urandom_range(0, 99) < 20);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0]    n;
    logic [CFG_DATA_W-1:0] radix_word;
    int unsigned           bits;
    in_ch.valid     = 1'b0;
    in_ch.a_operand = '0;
    in_ch.b_operand = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MODULUS;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings out of reset: N = 3, R = 4.
    send_pair(64'd0, 64'd0);
    send_pair(64'd1, 64'd1);
    send_pair(64'd2, 64'd2);
    send_pair(64'd2, 64'd1);
    send_pair(ALL_ONES, ALL_ONES);
    pause_sender(1);
    send_random_pairs(15, 64'd3, 8);
    wait_drained();

    // Largest modulus with a full-width radix, where the sum carries out.
    n = ALL_ONES;
    set_config(n, 64'd64, neg_inverse_of(n, 64));
    send_pair(64'd0, 64'd0);
    send_pair(64'd1, 64'd1);
    send_pair(n - 1, n - 1);
    send_pair(n - 1, 64'd1);
    send_pair(64'd1, n - 1);
    send_pair(ALL_ONES, ALL_ONES);
    send_pair(64'h8000_0000_0000_0000, 64'd2);
    send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    pause_sender(2);
    send_random_pairs(25, n, 24);
    wait_drained();

    set_config(64'd3, 64'd2, neg_inverse_of(64'd3, 2));
    send_random_pairs(25, 64'd3, 24);

    // Proper settings: odd N with R the smallest power of two above it.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      bits = $urandom_range(2, 64);
      n = random_word() >> (FIELD_W - bits);
      n[bits-1] = 1'b1;
      n[0] = 1'b1;
      set_config(n, CFG_DATA_W'(bits), neg_inverse_of(n, bits));
      if (ph == 1 || ph == 4) begin
        // Stall the product side long enough that the pipeline fills up and
        // refuses further operand transactions.
        hold_requests <= hold_requests + 1;
        send_random_pairs(30, n, 30);
      end
      send_random_pairs(25, n, 24);
      wait_drained();
      send_random_pairs(10, n, 24);
    end
    wait_drained();

    // Radix zero: R = 1, so the product is a*b with at most one subtraction of N.
    n = random_word() | 64'd1;
    set_config(n, 64'd0, random_word());
    send_random_pairs(20, n, 24);
    wait_drained();

    // A radix above the datapath width behaves as a full-width one.
    n = random_word() | 64'h8000_0000_0000_0001;
    set_config(n, 64'd127, neg_inverse_of(n, 64));
    send_random_pairs(20, n, 24);
    wait_drained();

    n = random_word() | 64'd1;
    radix_word = random_word();
    radix_word[RADIX_W-1:0] = 7'd65;
    set_config(n, radix_word, neg_inverse_of(n, 64));
    send_random_pairs(20, n, 24);
    wait_drained();

    // Even modulus: no modular meaning, the datapath still runs.
    n = random_word() & ~64'd1;
    set_config(n, CFG_DATA_W'($urandom_range(1, 64)), ALL_ONES);
    send_random_pairs(20, n, 24);
    wait_drained();

    set_config(64'd0, 64'd1, 64'd0);
    send_random_pairs(20, 64'd0, 24);
    wait_drained();

    set_config(64'd1, 64'd1, 64'd1);
    send_random_pairs(20, 64'd1, 24);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && products_pending == 0) begin
      $display("montgomery_product_unit verification clean");
    end else begin
      $display("montgomery_product_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("montgomery_product_unit verification failed");
    $finish;
  end

endmodule
